/* sv/gcib_pkg.sv */
// Package: shared constants, CORDIC angle table and word types.
`timescale 1ns / 1ps
package gcib_pkg;
	localparam int STEPS = 30;
	localparam int ZW = 40;
	localparam int VW = 34;
	localparam longint NANO = 64'd1000000000;
	localparam logic signed [VW-1:0] CORDIC_START = 34'sd652032874;

	// 1e9 = 2^9 * 5^9: take the power of two off as a shift, then multiply by
	// ceil(2^75 / 5^9); exact for every dividend below about 9.4e16
	localparam int NANO_POW2 = 9;
	localparam int RECIP_W = 55;
	localparam int RECIP_SHIFT = 75;
	localparam logic [RECIP_W-1:0] RECIP_5P9 = 55'd19342813113834067;

	typedef logic signed [ZW-1:0] ang_t;
	typedef logic signed [VW-1:0] vec_t;

	function automatic ang_t atan_nano(input int i);
		ang_t r;
		case (i)
			0: r = 40'sd45000000000;
			1: r = 40'sd26565051177;
			2: r = 40'sd14036243468;
			3: r = 40'sd7125016349;
			4: r = 40'sd3576334375;
			5: r = 40'sd1789910608;
			6: r = 40'sd895173710;
			7: r = 40'sd447614171;
			8: r = 40'sd223810500;
			9: r = 40'sd111905677;
			10: r = 40'sd55952892;
			11: r = 40'sd27976453;
			12: r = 40'sd13988227;
			13: r = 40'sd6994114;
			14: r = 40'sd3497057;
			15: r = 40'sd1748528;
			16: r = 40'sd874264;
			17: r = 40'sd437132;
			18: r = 40'sd218566;
			19: r = 40'sd109283;
			20: r = 40'sd54642;
			21: r = 40'sd27321;
			22: r = 40'sd13660;
			23: r = 40'sd6830;
			24: r = 40'sd3415;
			25: r = 40'sd1708;
			26: r = 40'sd854;
			27: r = 40'sd427;
			28: r = 40'sd213;
			29: r = 40'sd107;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

/* sv/gcib_if.sv */
// Interfaces: input and output channels with valid/ready handshake.
`timescale 1ns / 1ps
interface gcib_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] from_declination;
	logic [24:0] from_hour_angle;
	logic signed [23:0] to_declination;
	logic [24:0] to_hour_angle;
	modport source(output valid, from_declination, from_hour_angle, to_declination,
		to_hour_angle, input ready);
	modport sink(input valid, from_declination, from_hour_angle, to_declination,
		to_hour_angle, output ready);
endinterface

interface gcib_out_if;
	logic valid;
	logic ready;
	logic [24:0] bearing;
	modport source(output valid, bearing, input ready);
	modport sink(input valid, bearing, output ready);
endinterface

/* sv/gcib_rot_cell.sv */
// Rotation-mode CORDIC cell: one micro-rotation toward residual angle zero.
`timescale 1ns / 1ps
module gcib_rot_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               en,
	input  gcib_pkg::vec_t     x_in,
	input  gcib_pkg::vec_t     y_in,
	input  gcib_pkg::ang_t     z_in,
	output gcib_pkg::vec_t     x_s1,
	output gcib_pkg::vec_t     y_s1,
	output gcib_pkg::ang_t     z_s1
);
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[gcib_pkg::ZW-1]) begin
				x_s1 <= x_in - (y_in >>> STEP);
				y_s1 <= y_in + (x_in >>> STEP);
				z_s1 <= z_in - gcib_pkg::atan_nano(STEP);
			end else begin
				x_s1 <= x_in + (y_in >>> STEP);
				y_s1 <= y_in - (x_in >>> STEP);
				z_s1 <= z_in + gcib_pkg::atan_nano(STEP);
			end
		end
	end
endmodule

/* sv/gcib_vec_cell.sv */
// Vectoring-mode CORDIC cell: one micro-rotation driving y toward zero.
`timescale 1ns / 1ps
module gcib_vec_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               en,
	input  gcib_pkg::vec_t     x_in,
	input  gcib_pkg::vec_t     y_in,
	input  gcib_pkg::ang_t     z_in,
	output gcib_pkg::vec_t     x_s1,
	output gcib_pkg::vec_t     y_s1,
	output gcib_pkg::ang_t     z_s1
);
	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[gcib_pkg::VW-1] && y_in != '0) begin
				x_s1 <= x_in + (y_in >>> STEP);
				y_s1 <= y_in - (x_in >>> STEP);
				z_s1 <= z_in + gcib_pkg::atan_nano(STEP);
			end else begin
				x_s1 <= x_in - (y_in >>> STEP);
				y_s1 <= y_in + (x_in >>> STEP);
				z_s1 <= z_in - gcib_pkg::atan_nano(STEP);
			end
		end
	end
endmodule

/* sv/gcib_sincos.sv */
// Sine/cosine unit: angle folding, nano-degree scaling and a chain of rotation cells.
`timescale 1ns / 1ps
module gcib_sincos #(
	parameter int FRAC = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [26:0]    ang,
	output gcib_pkg::vec_t        sin_o,
	output gcib_pkg::vec_t        cos_o
);
	localparam int NS = gcib_pkg::STEPS;
	localparam longint UNIT = 64'd1 << FRAC;
	localparam longint FULL = 360 * UNIT;
	localparam int AW = FRAC + 11;

	logic signed [AW-1:0] red, fold;
	logic neg;
	logic signed [AW+31:0] prod;
	gcib_pkg::ang_t z0_s1;
	logic neg_s1;
	gcib_pkg::vec_t xs [NS+1];
	gcib_pkg::vec_t ys [NS+1];
	gcib_pkg::ang_t zs [NS+1];
	logic neg_p [NS+1];

	// reduce into [-180,180): input lies in (-512,512), two corrections suffice
	always_comb begin
		logic signed [AW+1:0] a;
		a = (AW+2)'(ang);
		if (a < 0) a = a + (AW+2)'(FULL);
		if (a >= (AW+2)'(FULL)) a = a - (AW+2)'(FULL);
		if (a >= (AW+2)'(180 * UNIT)) a = a - (AW+2)'(FULL);
		red = AW'(a);
		neg = 1'b0;
		fold = red;
		if (red > AW'(90 * UNIT)) begin
			fold = red - AW'(180 * UNIT);
			neg = 1'b1;
		end else if (red < -AW'(90 * UNIT)) begin
			fold = red + AW'(180 * UNIT);
			neg = 1'b1;
		end
		prod = (AW+32)'(fold) * (AW+32)'($signed(gcib_pkg::NANO));
	end

	// truncate toward zero while dividing by 2^FRAC
	always_ff @(posedge clk) begin
		if (en) begin
			if (prod[AW+31])
				z0_s1 <= gcib_pkg::ZW'(-((-prod) >>> FRAC));
			else
				z0_s1 <= gcib_pkg::ZW'(prod >>> FRAC);
			neg_s1 <= neg;
		end
	end

	assign xs[0] = gcib_pkg::CORDIC_START;
	assign ys[0] = '0;
	assign zs[0] = z0_s1;
	assign neg_p[0] = neg_s1;

	for (genvar i = 0; i < NS; i++) begin : g_cell
		gcib_rot_cell #(.STEP(i)) u_cell (
			.clk(clk), .en(en),
			.x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
			.x_s1(xs[i+1]), .y_s1(ys[i+1]), .z_s1(zs[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) neg_p[i+1] <= neg_p[i];
		end
	end

	assign sin_o = neg_p[NS] ? -ys[NS] : ys[NS];
	assign cos_o = neg_p[NS] ? -xs[NS] : xs[NS];
endmodule

/* sv/great_circle_initial_bearing.sv */
// Top level: great-circle initial bearing pipeline.
`timescale 1ns / 1ps
// Initial great-circle bearing from point 0 to point 1. Every word enters a
// fixed pipeline: three parallel sine/cosine chains of 30 CORDIC cells behind
// one scaling stage, three multiply stages forming y and x, a setup stage, a
// vectoring chain of 30 CORDIC cells for atan2, and three rounding stages
// (scale, reciprocal partial products, sum and wrap). One word is accepted
// each cycle while the pipeline advances; the two CORDIC cell chains make up
// most of its depth. The whole pipeline advances when the output register is
// empty or being taken, and holds otherwise.
module great_circle_initial_bearing #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	gcib_in_if.sink   in_ch,
	gcib_out_if.source out_ch
);
	localparam int NS = gcib_pkg::STEPS;
	localparam int VW = gcib_pkg::VW;
	localparam int ZW = gcib_pkg::ZW;
	localparam int LAT = NS + 1 + 3 + 1 + NS + 3;
	localparam longint UNIT = 64'd1 << ANGLE_FRAC_BITS;
	localparam longint NANO = gcib_pkg::NANO;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[LAT-1];

	logic signed [26:0] lha;
	assign lha = 27'(signed'({2'b0, in_ch.from_hour_angle}))
		- 27'(signed'({2'b0, in_ch.to_hour_angle}));

	gcib_pkg::vec_t s0, c0, s1, c1, sl, cl;
	gcib_sincos #(.FRAC(ANGLE_FRAC_BITS)) u_d0 (.clk(clk), .en(en),
		.ang(27'(in_ch.from_declination)), .sin_o(s0), .cos_o(c0));
	gcib_sincos #(.FRAC(ANGLE_FRAC_BITS)) u_d1 (.clk(clk), .en(en),
		.ang(27'(in_ch.to_declination)), .sin_o(s1), .cos_o(c1));
	gcib_sincos #(.FRAC(ANGLE_FRAC_BITS)) u_lha (.clk(clk), .en(en),
		.ang(lha), .sin_o(sl), .cos_o(cl));

	// products: stage 1 forms c1*sl, c0*s1, s0*c1; stage 2 multiplies by cl
	logic signed [2*VW-1:0] p_y, p_a, p_b, p_c;
	gcib_pkg::vec_t y_s1, a_s1, b_s1, cl_s1, y_s2, a_s2, c_s2;
	gcib_pkg::vec_t y_s3, x_s3;
	always_comb begin
		p_y = (2*VW)'(c1) * (2*VW)'(sl);
		p_a = (2*VW)'(c0) * (2*VW)'(s1);
		p_b = (2*VW)'(s0) * (2*VW)'(c1);
		p_c = (2*VW)'(b_s1) * (2*VW)'(cl_s1);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= VW'(p_y >>> 30);
			a_s1 <= VW'(p_a >>> 30);
			b_s1 <= VW'(p_b >>> 30);
			cl_s1 <= cl;
			y_s2 <= y_s1;
			a_s2 <= a_s1;
			c_s2 <= VW'(p_c >>> 30);
			y_s3 <= y_s2;
			x_s3 <= a_s2 - c_s2;
		end
	end

	// set up vectoring: special cases and half-turn for negative x
	gcib_pkg::vec_t vx_d, vy_d, vx_s4, vy_s4;
	gcib_pkg::ang_t vz_d, fix_d, vz_s4, fix_s4;
	logic fixed_d, fixed_s4;
	always_comb begin
		fixed_d = 1'b1;
		vx_d = x_s3;
		vy_d = y_s3;
		vz_d = '0;
		fix_d = '0;
		if (y_s3 == '0 && !x_s3[VW-1]) fix_d = '0;
		else if (y_s3 == '0) fix_d = ZW'(180 * NANO);
		else if (x_s3 == '0)
			fix_d = y_s3[VW-1] ? ZW'(270 * NANO) : ZW'(90 * NANO);
		else begin
			fixed_d = 1'b0;
			if (x_s3[VW-1]) begin
				vx_d = -x_s3;
				vy_d = -y_s3;
				vz_d = ZW'(180 * NANO);
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fixed_s4 <= fixed_d;
			fix_s4 <= fix_d;
			vx_s4 <= vx_d;
			vy_s4 <= vy_d;
			vz_s4 <= vz_d;
		end
	end

	gcib_pkg::vec_t vxs [NS+1];
	gcib_pkg::vec_t vys [NS+1];
	gcib_pkg::ang_t vzs [NS+1];
	logic fx_p [NS+1];
	gcib_pkg::ang_t fz_p [NS+1];
	assign vxs[0] = vx_s4;
	assign vys[0] = vy_s4;
	assign vzs[0] = vz_s4;
	assign fx_p[0] = fixed_s4;
	assign fz_p[0] = fix_s4;
	for (genvar i = 0; i < NS; i++) begin : g_vec
		gcib_vec_cell #(.STEP(i)) u_cell (
			.clk(clk), .en(en),
			.x_in(vxs[i]), .y_in(vys[i]), .z_in(vzs[i]),
			.x_s1(vxs[i+1]), .y_s1(vys[i+1]), .z_s1(vzs[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				fx_p[i+1] <= fx_p[i];
				fz_p[i+1] <= fz_p[i];
			end
		end
	end

	// wrap, scale to degrees*2^F with half-up rounding, wrap at 360;
	// divide by 1e9 as a shift, then a reciprocal multiply split in 28-bit pieces
	localparam int PW = ZW + ANGLE_FRAC_BITS + 2;
	localparam int MW = ANGLE_FRAC_BITS + 30;
	localparam int QW = ANGLE_FRAC_BITS + 10;
	localparam int PIECE = 28;
	localparam int SW = MW + gcib_pkg::RECIP_W;
	gcib_pkg::ang_t zf;
	logic [PW-1:0] num;
	logic [MW-1:0] m_s1;
	logic [2*PIECE-1:0] hh_s2, hl_s2, lh_s2, ll_s2;
	logic [SW-1:0] psum;
	logic [QW-1:0] q;
	logic [24:0] bearing_q;
	always_comb begin
		zf = fx_p[NS] ? fz_p[NS] : vzs[NS];
		if (zf < 0) zf = zf + ZW'(360 * NANO);
		if (zf < 0) zf = '0;
		num = (PW'($unsigned(zf)) << ANGLE_FRAC_BITS) + PW'(NANO / 2);
	end
	always_ff @(posedge clk) begin
		if (en) m_s1 <= MW'(num >> gcib_pkg::NANO_POW2);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s2 <= (2*PIECE)'(m_s1[MW-1:PIECE])
				* (2*PIECE)'(gcib_pkg::RECIP_5P9[gcib_pkg::RECIP_W-1:PIECE]);
			hl_s2 <= (2*PIECE)'(m_s1[MW-1:PIECE])
				* (2*PIECE)'(gcib_pkg::RECIP_5P9[PIECE-1:0]);
			lh_s2 <= (2*PIECE)'(m_s1[PIECE-1:0])
				* (2*PIECE)'(gcib_pkg::RECIP_5P9[gcib_pkg::RECIP_W-1:PIECE]);
			ll_s2 <= (2*PIECE)'(m_s1[PIECE-1:0])
				* (2*PIECE)'(gcib_pkg::RECIP_5P9[PIECE-1:0]);
		end
	end
	always_comb begin
		psum = (SW'(hh_s2) << (2*PIECE)) + (SW'(hl_s2) << PIECE)
			+ (SW'(lh_s2) << PIECE) + SW'(ll_s2);
		q = QW'(psum >> gcib_pkg::RECIP_SHIFT);
		if (q >= QW'(360 * UNIT)) q = q - QW'(360 * UNIT);
	end
	always_ff @(posedge clk) begin
		if (en) bearing_q <= 25'(q);
	end
	assign out_ch.bearing = bearing_q;
endmodule

/* dv/tb_top.sv */
// Testbench for the great-circle initial bearing block: directed and random point pairs.
`timescale 1ns / 1ps
module tb_top;
	localparam int FRAC = 16;
	localparam longint UNIT = 64'sd1 << FRAC;
	localparam longint FULL_TURN = 360 * UNIT;
	localparam longint NANO = gcib_pkg::NANO;
	localparam int STEPS = gcib_pkg::STEPS;
	localparam int LATENCY = 68;
	localparam int RANDOM_WORDS = 1250;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [23:0] from_dec;
		logic [24:0] from_gha;
		logic signed [23:0] to_dec;
		logic [24:0] to_gha;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gcib_in_if in_ch ();
	gcib_out_if out_ch ();

	great_circle_initial_bearing #(.ANGLE_FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #6 clk = ~clk;

	pair_t pending_pairs[$];
	logic [24:0] expected_bearings[$];
	int errors = 0;
	int received = 0;
	longint cycles = 0;

	// Floor shift for signed values, matching the datapath's arithmetic shift.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	// Sine and cosine in Q30 from an angle in degrees times 2^FRAC.
	function automatic void cordic_sin_cos(longint a, output longint s, output longint c);
		longint x, y, z, t;
		bit flip;
		x = gcib_pkg::CORDIC_START;
		y = 0;
		flip = 0;
		a = a % FULL_TURN;
		if (a < 0) a += FULL_TURN;
		if (a >= 180 * UNIT) a -= FULL_TURN;
		if (a > 90 * UNIT) begin
			a -= 180 * UNIT;
			flip = 1;
		end else if (a < -90 * UNIT) begin
			a += 180 * UNIT;
			flip = 1;
		end
		// Division truncates toward zero, as the conversion requires.
		z = (a * NANO) / UNIT;
		for (int i = 0; i < STEPS; i++) begin
			longint step;
			step = gcib_pkg::atan_nano(i);
			if (z >= 0) begin
				t = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= step;
			end else begin
				t = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += step;
			end
			x = t;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, t;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 180 * NANO;
		end
		for (int i = 0; i < STEPS; i++) begin
			longint step;
			step = gcib_pkg::atan_nano(i);
			if (y > 0) begin
				t = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += step;
			end else begin
				t = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= step;
			end
			x = t;
		end
		return z;
	endfunction

	function automatic logic [24:0] predict_bearing(pair_t p);
		longint s0, c0, s1, c1, sl, cl, y, x, z, r;
		cordic_sin_cos(longint'(p.from_dec), s0, c0);
		cordic_sin_cos(longint'(p.to_dec), s1, c1);
		cordic_sin_cos(longint'(p.from_gha) - longint'(p.to_gha), sl, cl);
		y = floor_shift(c1 * sl, 30);
		x = floor_shift(c0 * s1, 30) - floor_shift(floor_shift(s0 * c1, 30) * cl, 30);
		// Axis-aligned vectors take exact quadrant angles; the origin maps to north.
		if (y == 0 && x >= 0) z = 0;
		else if (y == 0) z = 180 * NANO;
		else if (x == 0) z = (y > 0) ? 90 * NANO : 270 * NANO;
		else z = vector_angle(y, x);
		if (z < 0) z += 360 * NANO;
		if (z < 0) z = 0;
		r = (z * UNIT + NANO / 2) / NANO;
		if (r >= FULL_TURN) r -= FULL_TURN;
		if (r < 0) r = 0;
		return r[24:0];
	endfunction

	// Most gaps short, a few long.
	function automatic int gap_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [23:0] any_dec();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 24'($urandom);
		return 24'sd0 + 24'($signed($urandom_range(0, 11796480)) - 5898240);
	endfunction

	function automatic logic [24:0] any_gha();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 25'($urandom);
		return 25'($urandom_range(0, 23592959));
	endfunction

	task automatic push_pair(int fd, int fg, int td, int tg);
		pair_t p;
		p.from_dec = 24'(fd);
		p.from_gha = 25'(tg * 0 + fg);
		p.to_dec = 24'(td);
		p.to_gha = 25'(tg);
		pending_pairs.push_back(p);
	endtask

	task automatic report_mismatch(string what, logic [24:0] got, logic [24:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Acceptance is seen at the rising edge, where it happens.
	bit in_taken = 0;
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_bearings.push_back(predict_bearing(pending_pairs.pop_front()));
			in_taken = 1'b1;
		end
	end

	// Driver: present a word at the falling edge, hold until it is taken.
	int send_gap = 0;
	always @(negedge clk) begin
		bit hold;
		if (arst_n) begin
			hold = in_ch.valid;
			if (in_taken) begin
				in_taken = 1'b0;
				hold = 1'b0;
				send_gap = gap_length();
			end
			if (!hold) begin
				if (send_gap > 0 || pending_pairs.size() == 0) begin
					if (send_gap > 0) send_gap--;
					in_ch.valid <= 1'b0;
				end else begin
					in_ch.valid <= 1'b1;
					{in_ch.from_declination, in_ch.from_hour_angle,
						in_ch.to_declination, in_ch.to_hour_angle} <= pending_pairs[0];
				end
			end
		end
	end

	// Sink stall pattern changes at the falling edge as well.
	int stall_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				stall_left = gap_length();
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: check each taken bearing against the oldest prediction.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			received++;
			if (expected_bearings.size() == 0) begin
				report_mismatch("bearing without pending word", out_ch.bearing, '0);
			end else begin
				logic [24:0] want;
				want = expected_bearings.pop_front();
				if (out_ch.bearing !== want) report_mismatch("bearing", out_ch.bearing, want);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.from_declination = '0;
		in_ch.from_hour_angle = '0;
		in_ch.to_declination = '0;
		in_ch.to_hour_angle = '0;
		out_ch.ready = 1'b0;
		// Directed: poles, equator, coincident points, field extremes, out-of-range codes.
		push_pair(0, 0, 0, 0);
		push_pair(5898240, 0, -5898240, 0);
		push_pair(-5898240, 0, 5898240, 0);
		push_pair(0, 0, 5898240, 100);
		push_pair(0, 0, -5898240, 100);
		push_pair(0, 0, 0, 90 * 65536);
		push_pair(0, 90 * 65536, 0, 0);
		push_pair(0, 0, 0, 180 * 65536);
		push_pair(0, 23592959, 0, 0);
		push_pair(0, 0, 0, 23592959);
		push_pair(5898240, 1000, 5898240, 5000);
		push_pair(2949120, 0, 2949120, 0);
		push_pair(2949120, 10 * 65536, -2949120, 200 * 65536);
		push_pair(8388607, 33554431, -8388608, 0);
		push_pair(-8388608, 0, 8388607, 33554431);
		push_pair(-1, 1, 1, 0);
		push_pair(0, 33554431, 0, 33554431);
		push_pair(-5898240, 45 * 65536, -5898240, 300 * 65536);
		push_pair(1, 0, 0, 0);
		push_pair(0, 0, 1, 0);
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			int fd, fg;
			fd = any_dec();
			fg = any_gha();
			// Some pairs stay close together so small vectors get exercised.
			if ($urandom_range(0, 7) == 0)
				push_pair(fd, fg, fd + $signed($urandom_range(0, 64)) - 32,
					fg + $urandom_range(0, 64));
			else
				push_pair(fd, fg, any_dec(), any_gha());
		end
		wait (pending_pairs.size() == 0);
		wait (expected_bearings.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
